### sv/tap_tempo_beat_tracker_defines.svh
// Assertion helpers for the beat tracker.
// Each macro expects clk and rst_n in scope at the point of use.
`ifndef TAP_TEMPO_BEAT_TRACKER_DEFINES_SVH
`define TAP_TEMPO_BEAT_TRACKER_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent
`define TTB_ASSERT_NOW(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent
`define TTB_ASSERT_NEXT(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### sv/ttb_pkg.sv
package ttb_pkg;

    // Field and state widths
    localparam int PHASE_BITS      = 48;
    localparam int RATE_FRAC_BITS  = 16;
    localparam int RATE_INT_BITS   = 12;
    localparam int RATE_BITS       = RATE_INT_BITS + RATE_FRAC_BITS;
    localparam int TIME_BITS       = 32;
    localparam int TEMPO_BITS      = 26;
    localparam int TEMPO_FRAC_BITS = 8;

    // Phase increment: elapsed * rate with the rate fraction dropped
    localparam int INC_BITS = RATE_BITS + TIME_BITS - RATE_FRAC_BITS;

    // Beat arithmetic in millibeats
    localparam int BEAT_MB      = 1000;
    localparam int HALF_BEAT_MB = 500;
    localparam int ERR_SPAN_MB  = BEAT_MB + HALF_BEAT_MB;
    localparam int REM_BITS     = $clog2(BEAT_MB);
    localparam int SPAN_BITS    = $clog2(ERR_SPAN_MB + 1);
    localparam int NUM_BITS     = SPAN_BITS + RATE_FRAC_BITS;

    // Tempo conversion
    localparam int RESET_BPM   = 140;
    localparam int SEC_PER_MIN = 60;
    localparam logic [RATE_BITS-1:0] RATE_RESET =
        RATE_BITS'((64'(RESET_BPM) << RATE_FRAC_BITS) / 64'(SEC_PER_MIN));

    // Serial digit sizes and step counts
    localparam int MUL_DIGIT = 2;
    localparam int MOD_DIGIT = 4;
    localparam int MUL_STEPS = TIME_BITS / MUL_DIGIT;
    localparam int MOD_STEPS = PHASE_BITS / MOD_DIGIT;
    localparam int DIV_STEPS = NUM_BITS;
    localparam int MAX_STEPS_A = (MUL_STEPS > MOD_STEPS) ? MUL_STEPS : MOD_STEPS;
    localparam int MAX_STEPS   = (MAX_STEPS_A > DIV_STEPS) ? MAX_STEPS_A : DIV_STEPS;
    localparam int CNT_BITS    = $clog2(MAX_STEPS + 1);

    // Request selector codes
    localparam logic REQ_TAP   = 1'b0;
    localparam logic REQ_QUERY = 1'b1;

    typedef struct packed {
        logic                 req_type;
        logic [TIME_BITS-1:0] time_ms;
    } ttb_req_t;

    typedef struct packed {
        logic [PHASE_BITS-1:0] phase_mb;
        logic                  beat_flag;
        logic [TEMPO_BITS-1:0] tempo_bpm_q8;
    } ttb_rsp_t;

endpackage

### sv/tap_tempo_beat_tracker.sv
// Sequence: a request passes through the multiply, add, mod-1000 and tap states;
//   a tap with nonzero elapsed time also runs the divide and blend states.
// Throughput: a new request is taken only once the last is done, paced by the
//   2-bit serial multiplier, the 4-bit serial mod-1000 unit and the 1-bit divider;
//   a response held by rsp_ready low stalls the next one in ST_FIN until it is taken.
// Reset: rate returns to 140 BPM, anchor time, anchor phase and last phase to zero.
`include "tap_tempo_beat_tracker_defines.svh"

module tap_tempo_beat_tracker
    import ttb_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     req_valid,
    output logic     req_ready,
    input  ttb_req_t req,
    output logic     rsp_valid,
    input  logic     rsp_ready,
    output ttb_rsp_t rsp
);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_MUL   = 3'd1;
    localparam logic [2:0] ST_ADD   = 3'd2;
    localparam logic [2:0] ST_MOD   = 3'd3;
    localparam logic [2:0] ST_TAP   = 3'd4;
    localparam logic [2:0] ST_DIV   = 3'd5;
    localparam logic [2:0] ST_BLEND = 3'd6;
    localparam logic [2:0] ST_FIN   = 3'd7;

    // Control and architectural state
    logic [2:0]            state_reg, state_next;
    logic [CNT_BITS-1:0]   cnt_reg, cnt_next;
    logic                  rsp_valid_reg, rsp_valid_next;
    logic [RATE_BITS-1:0]  rate_reg, rate_next;
    logic [TIME_BITS-1:0]  anchor_ms_reg, anchor_ms_next;
    logic [PHASE_BITS-1:0] anchor_mb_reg, anchor_mb_next;
    logic [REM_BITS-1:0]   last_rem_reg, last_rem_next;

    // Working registers
    logic                  query_reg, query_next;
    logic [TIME_BITS-1:0]  time_reg, time_next;
    logic [TIME_BITS-1:0]  elapsed_reg, elapsed_next;
    logic [RATE_BITS-1:0]  acc_hi_reg, acc_hi_next;
    logic [TIME_BITS-1:0]  acc_lo_reg, acc_lo_next;
    logic [PHASE_BITS-1:0] phase_reg, phase_next;
    logic [REM_BITS-1:0]   rem_reg, rem_next;
    logic [TIME_BITS-1:0]  divrem_reg, divrem_next;
    logic [NUM_BITS-1:0]   dsh_reg, dsh_next;
    logic                  flag_reg, flag_next;
    ttb_rsp_t              rsp_reg, rsp_next;

    // Datapath temporaries
    logic [RATE_BITS-1:0]  mul_hi;
    logic [TIME_BITS-1:0]  mul_lo;
    logic [RATE_BITS:0]    mul_sum;
    logic [INC_BITS-1:0]   inc;
    logic [REM_BITS-1:0]   mod_r;
    logic [REM_BITS:0]     mod_t;
    logic [REM_BITS:0]     err_off;
    logic [SPAN_BITS-1:0]  span;
    logic [TIME_BITS:0]    trial;
    logic                  ge;
    logic [RATE_BITS+1:0]  blend_sum;
    logic [RATE_BITS+5:0]  rate_x60;
    logic                  last_step;

    assign req_ready = (state_reg == ST_IDLE);
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    always_comb
    begin
        // Multiplier: MUL_DIGIT shift-add steps, elapsed bits LSB first
        mul_hi  = acc_hi_reg;
        mul_lo  = acc_lo_reg;
        mul_sum = '0;
        for (int i = 0; i < MUL_DIGIT; i++)
        begin
            mul_sum = {1'b0, mul_hi} + (mul_lo[0] ? {1'b0, rate_reg} : '0);
            mul_lo  = {mul_sum[0], mul_lo[TIME_BITS-1:1]};
            mul_hi  = mul_sum[RATE_BITS:1];
        end

        // Product bits above the rate fraction
        inc = {acc_hi_reg, acc_lo_reg[TIME_BITS-1:RATE_FRAC_BITS]};

        // Mod 1000: MOD_DIGIT restoring steps, phase bits MSB first
        mod_r = rem_reg;
        mod_t = '0;
        for (int i = 0; i < MOD_DIGIT; i++)
        begin
            mod_t = {mod_r, phase_reg[PHASE_BITS-1-i]};
            if (mod_t >= (REM_BITS+1)'(BEAT_MB))
            begin
                mod_t = mod_t - (REM_BITS+1)'(BEAT_MB);
            end
            mod_r = mod_t[REM_BITS-1:0];
        end

        // Offset error to nearest beat, 0..999, and 1500 - error
        err_off = {1'b0, rem_reg} + (REM_BITS+1)'(HALF_BEAT_MB);
        if (err_off >= (REM_BITS+1)'(BEAT_MB))
        begin
            err_off = err_off - (REM_BITS+1)'(BEAT_MB);
        end
        span = SPAN_BITS'(ERR_SPAN_MB) - SPAN_BITS'(err_off);

        // Divider: one restoring step
        trial = {divrem_reg, dsh_reg[NUM_BITS-1]};
        ge    = (trial >= {1'b0, elapsed_reg});

        // Blend 1/4 new to 3/4 old; the quotient is narrower than the rate,
        // so it never reaches the rate maximum
        blend_sum = (RATE_BITS+2)'(dsh_reg) + {2'b00, rate_reg} + {1'b0, rate_reg, 1'b0};

        // rate * 60 as rate * 64 - rate * 4
        rate_x60 = {rate_reg, 6'b0} - {4'b0, rate_reg, 2'b0};
    end

    // Sequencer
    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        rsp_valid_next = rsp_valid_reg && !rsp_ready;
        rate_next      = rate_reg;
        anchor_ms_next = anchor_ms_reg;
        anchor_mb_next = anchor_mb_reg;
        last_rem_next  = last_rem_reg;
        query_next     = query_reg;
        time_next      = time_reg;
        elapsed_next   = elapsed_reg;
        acc_hi_next    = acc_hi_reg;
        acc_lo_next    = acc_lo_reg;
        phase_next     = phase_reg;
        rem_next       = rem_reg;
        divrem_next    = divrem_reg;
        dsh_next       = dsh_reg;
        flag_next      = flag_reg;
        rsp_next       = rsp_reg;
        last_step      = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (req_valid)
                begin
                    query_next   = (req.req_type == REQ_QUERY);
                    time_next    = req.time_ms;
                    elapsed_next = req.time_ms - anchor_ms_reg;
                    acc_hi_next  = '0;
                    acc_lo_next  = req.time_ms - anchor_ms_reg;
                    cnt_next     = '0;
                    state_next   = ST_MUL;
                end
            end
            ST_MUL:
            begin
                acc_hi_next = mul_hi;
                acc_lo_next = mul_lo;
                cnt_next    = cnt_reg + 1'b1;
                last_step   = (cnt_reg == CNT_BITS'(MUL_STEPS - 1));
                if (last_step)
                begin
                    state_next = ST_ADD;
                end
            end
            ST_ADD:
            begin
                phase_next = anchor_mb_reg + PHASE_BITS'(inc);
                rem_next   = '0;
                cnt_next   = '0;
                state_next = ST_MOD;
            end
            ST_MOD:
            begin
                rem_next   = mod_r;
                // Rotate so the phase is whole again after the last step
                phase_next = {phase_reg[PHASE_BITS-MOD_DIGIT-1:0],
                              phase_reg[PHASE_BITS-1 -: MOD_DIGIT]};
                cnt_next   = cnt_reg + 1'b1;
                last_step  = (cnt_reg == CNT_BITS'(MOD_STEPS - 1));
                if (last_step)
                begin
                    state_next = ST_TAP;
                end
            end
            ST_TAP:
            begin
                if (query_reg)
                begin
                    flag_next     = (rem_reg < last_rem_reg);
                    last_rem_next = rem_reg;
                    state_next    = ST_FIN;
                end
                else
                begin
                    flag_next      = 1'b0;
                    anchor_ms_next = time_reg;
                    anchor_mb_next = phase_reg;
                    divrem_next    = '0;
                    dsh_next       = {span, RATE_FRAC_BITS'(0)};
                    cnt_next       = '0;
                    // Zero elapsed time keeps the old rate
                    state_next     = (elapsed_reg != '0) ? ST_DIV : ST_FIN;
                end
            end
            ST_DIV:
            begin
                divrem_next = ge ? TIME_BITS'(trial - {1'b0, elapsed_reg})
                                 : trial[TIME_BITS-1:0];
                dsh_next    = {dsh_reg[NUM_BITS-2:0], ge};
                cnt_next    = cnt_reg + 1'b1;
                last_step   = (cnt_reg == CNT_BITS'(DIV_STEPS - 1));
                if (last_step)
                begin
                    state_next = ST_BLEND;
                end
            end
            ST_BLEND:
            begin
                rate_next  = blend_sum[RATE_BITS+1:2];
                state_next = ST_FIN;
            end
            ST_FIN:
            begin
                // Load the output register once it is free
                if (!rsp_valid_reg || rsp_ready)
                begin
                    rsp_next.phase_mb     = phase_reg;
                    rsp_next.beat_flag    = flag_reg;
                    rsp_next.tempo_bpm_q8 =
                        TEMPO_BITS'(rate_x60 >> (RATE_FRAC_BITS - TEMPO_FRAC_BITS));
                    rsp_valid_next        = 1'b1;
                    state_next            = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control and architectural state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            rsp_valid_reg <= 1'b0;
            rate_reg      <= RATE_RESET;
            anchor_ms_reg <= '0;
            anchor_mb_reg <= '0;
            last_rem_reg  <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            rsp_valid_reg <= rsp_valid_next;
            rate_reg      <= rate_next;
            anchor_ms_reg <= anchor_ms_next;
            anchor_mb_reg <= anchor_mb_next;
            last_rem_reg  <= last_rem_next;
        end
    end

    // Working registers
    always_ff @(posedge clk)
    begin
        query_reg   <= query_next;
        time_reg    <= time_next;
        elapsed_reg <= elapsed_next;
        acc_hi_reg  <= acc_hi_next;
        acc_lo_reg  <= acc_lo_next;
        phase_reg   <= phase_next;
        rem_reg     <= rem_next;
        divrem_reg  <= divrem_next;
        dsh_reg     <= dsh_next;
        flag_reg    <= flag_next;
        rsp_reg     <= rsp_next;
    end

    // Checks
    `TTB_ASSERT_NOW(a_div_nonzero, state_reg == ST_DIV, elapsed_reg != '0, "divide by zero elapsed")
    `TTB_ASSERT_NOW(a_flag_query, (state_reg == ST_FIN) && !query_reg, !flag_reg, "beat flag on tap")
    `TTB_ASSERT_NEXT(a_rate_hold, state_reg != ST_BLEND, $stable(rate_reg), "rate moved outside blend")
    `TTB_ASSERT_NEXT(a_anchor_hold, state_reg != ST_TAP, $stable(anchor_ms_reg), "anchor moved outside tap")

endmodule

### sim/beat_phase_checker.sv
`timescale 1ns / 1ps

// Watches both channels of the beat tracker, predicts every response and
// compares it against what the block returns, in order.
module beat_phase_checker
    import ttb_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     req_valid,
    input  logic     req_ready,
    input  ttb_req_t req,
    input  logic     rsp_valid,
    input  logic     rsp_ready,
    input  ttb_rsp_t rsp,
    output int       mismatches,
    output int       outstanding
);

    localparam logic [63:0] RATE_MAX = (64'(1) << RATE_BITS) - 64'(1);

    // Tracker state as this side sees it
    logic [RATE_BITS-1:0]  rate_q;
    logic [TIME_BITS-1:0]  anchor_time;
    logic [PHASE_BITS-1:0] anchor_phase;
    logic [PHASE_BITS-1:0] prev_query_phase;

    ttb_rsp_t expected_beats[$];
    int       miss_count;

    // Phase, beat flag and tempo for one request; taps also retune the rate
    // and move the anchor, queries remember the phase they reported.
    function automatic ttb_rsp_t next_beat_report(input ttb_req_t r);
        logic [TIME_BITS-1:0]  elapsed;
        logic [63:0]           inc;
        logic [PHASE_BITS-1:0] phase;
        logic [63:0]           rem;
        logic [63:0]           err_off;
        logic [63:0]           fresh;
        ttb_rsp_t              o;
        elapsed = r.time_ms - anchor_time;
        inc = 64'(elapsed) * 64'(rate_q[RATE_BITS-1:RATE_FRAC_BITS])
            + ((64'(elapsed) * 64'(rate_q[RATE_FRAC_BITS-1:0])) >> RATE_FRAC_BITS);
        phase = PHASE_BITS'(64'(anchor_phase) + inc);
        rem = 64'(phase) % 64'(BEAT_MB);
        o.phase_mb  = phase;
        o.beat_flag = 1'b0;
        if (r.req_type == REQ_QUERY)
        begin
            if (rem < (64'(prev_query_phase) % 64'(BEAT_MB)))
                o.beat_flag = 1'b1;
            prev_query_phase = phase;
        end
        else
        begin
            // offset error to nearest beat, 0..999
            err_off = (rem + 64'(HALF_BEAT_MB)) % 64'(BEAT_MB);
            if (elapsed != '0)
            begin
                fresh = ((64'(ERR_SPAN_MB) - err_off) << RATE_FRAC_BITS) / 64'(elapsed);
                if (fresh > RATE_MAX)
                    fresh = RATE_MAX;
                rate_q = RATE_BITS'((fresh + 64'(3) * 64'(rate_q)) >> 2);
            end
            anchor_time  = r.time_ms;
            anchor_phase = phase;
        end
        o.tempo_bpm_q8 = TEMPO_BITS'((64'(rate_q) * 64'(SEC_PER_MIN))
                                     >> (RATE_FRAC_BITS - TEMPO_FRAC_BITS));
        return o;
    endfunction

    // Predict on each request transaction, compare on each response
    always @(posedge clk or negedge rst_n)
    begin
        ttb_rsp_t want;
        if (!rst_n)
        begin
            rate_q           = RATE_BITS'((64'(RESET_BPM) << RATE_FRAC_BITS)
                                          / 64'(SEC_PER_MIN));
            anchor_time      = '0;
            anchor_phase     = '0;
            prev_query_phase = '0;
            expected_beats.delete();
            miss_count  = 0;
            mismatches  <= 0;
            outstanding <= 0;
        end
        else
        begin
            if (req_valid && req_ready)
                expected_beats.push_back(next_beat_report(req));
            if (rsp_valid && rsp_ready)
            begin
                if (expected_beats.size() == 0)
                begin
                    miss_count++;
                    if (miss_count <= 10)
                        $display("%0t: unexpected response %0d/%0d/%0d",
                                 $realtime, rsp.phase_mb, rsp.beat_flag, rsp.tempo_bpm_q8);
                end
                else
                begin
                    want = expected_beats.pop_front();
                    if (want.phase_mb !== rsp.phase_mb || want.beat_flag !== rsp.beat_flag
                        || want.tempo_bpm_q8 !== rsp.tempo_bpm_q8)
                    begin
                        miss_count++;
                        if (miss_count <= 10)
                            $display("%0t: mismatch exp %0d/%0d/%0d got %0d/%0d/%0d",
                                     $realtime, want.phase_mb, want.beat_flag,
                                     want.tempo_bpm_q8, rsp.phase_mb, rsp.beat_flag,
                                     rsp.tempo_bpm_q8);
                    end
                end
            end
            mismatches  <= miss_count;
            outstanding <= expected_beats.size();
        end
    end

endmodule

### sim/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
    import ttb_pkg::*;

    localparam int TOTAL_ITEMS = 1300;
    localparam int CALM_ITEMS  = 150;
    localparam int DRAIN_AT    = 600;
    localparam int TAIL_CYCLES = 70;
    localparam int CYCLE_LIMIT = 800000;

    logic     clk = 1'b0;
    logic     rst_n;
    logic     req_valid;
    logic     req_ready;
    ttb_req_t req;
    logic     rsp_valid;
    logic     rsp_ready = 1'b0;
    ttb_rsp_t rsp;

    int mismatches;
    int outstanding;

    // stimulus bookkeeping
    int              sent = 0;
    logic            calm = 1'b0;
    logic            gap_mode = 1'b1;
    logic [31:0]     now = '0;
    int              cycle_count = 0;

    tap_tempo_beat_tracker dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp)
    );

    beat_phase_checker u_check (
        .clk         (clk),
        .rst_n       (rst_n),
        .req_valid   (req_valid),
        .req_ready   (req_ready),
        .req         (req),
        .rsp_valid   (rsp_valid),
        .rsp_ready   (rsp_ready),
        .rsp         (rsp),
        .mismatches  (mismatches),
        .outstanding (outstanding)
    );

    // 20 ns clock
    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Regression FAIL");
            $finish;
        end
    end

    // Response back-pressure: random stall bursts, with quiet stretches
    always @(negedge clk)
    begin
        int stall_left;
        logic stall_mode;
        if (!rst_n)
        begin
            stall_left = 0;
            stall_mode = 1'b1;
            rsp_ready <= 1'b0;
        end
        else
        begin
            if ($urandom_range(0, 199) == 0)
                stall_mode = !stall_mode;
            if (stall_left > 0)
            begin
                stall_left--;
                rsp_ready <= 1'b0;
            end
            else if (!calm && stall_mode && $urandom_range(0, 5) == 0)
            begin
                stall_left = $urandom_range(1, 5) - 1;
                rsp_ready <= 1'b0;
            end
            else
                rsp_ready <= 1'b1;
        end
    end

    task automatic hold_off(input int cycles);
        repeat (cycles)
        begin
            @(negedge clk);
            req_valid <= 1'b0;
        end
    endtask

    // One request transaction, with an occasional idle burst ahead of it
    task automatic send(input logic kind, input logic [31:0] stamp);
        ttb_req_t item;
        if (!calm && gap_mode && $urandom_range(0, 3) == 0)
            hold_off($urandom_range(1, 5));
        item.req_type = kind;
        item.time_ms  = stamp;
        @(negedge clk);
        req_valid <= 1'b1;
        req       <= item;
        do
            @(posedge clk);
        while (!req_ready);
        sent++;
        now = stamp;
        if ($urandom_range(0, 49) == 0)
            gap_mode = !gap_mode;
    endtask

    // Stop sending until the tracker has answered everything
    task automatic drain();
        @(negedge clk);
        req_valid <= 1'b0;
        while (outstanding != 0)
            @(posedge clk);
    endtask

    initial
    begin
        int   period;
        int   interval;
        int   taps;
        int   queries;
        int   jitter;
        logic drained;
        logic [31:0] base;
        rst_n     = 1'b0;
        req_valid = 1'b0;
        req       = '0;
        drained   = 1'b0;
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed: zero elapsed, beat wraps, fastest and slowest taps,
        // time wrapping forward past the top and stepping backwards.
        send(REQ_QUERY, 32'd0);
        send(REQ_TAP,   32'd0);
        send(REQ_QUERY, 32'd100);
        send(REQ_TAP,   32'd430);
        send(REQ_TAP,   32'd860);
        send(REQ_QUERY, 32'd900);
        send(REQ_QUERY, 32'd1000);
        send(REQ_QUERY, 32'd1300);
        send(REQ_TAP,   32'd861);
        send(REQ_TAP,   32'd862);
        send(REQ_TAP,   32'd863);
        send(REQ_TAP,   32'd864);
        send(REQ_QUERY, 32'd864);
        send(REQ_TAP,   32'hFFFF_FFFF);
        send(REQ_QUERY, 32'hFFFF_FFFF);
        send(REQ_TAP,   32'hFFFF_FFFF);
        send(REQ_TAP,   32'd5);
        send(REQ_QUERY, 32'd3);
        send(REQ_TAP,   32'd2);
        send(REQ_QUERY, 32'h8000_0000);
        send(REQ_TAP,   32'h8000_0190);
        send(REQ_QUERY, 32'h8000_019A);

        // Random: mostly steady tap runs with frame-rate queries in between,
        // the rest noise (wild timestamps, backward steps, forward jumps, double taps).
        while (sent < TOTAL_ITEMS)
        begin
            calm = (sent >= TOTAL_ITEMS - CALM_ITEMS);
            if (!drained && sent >= DRAIN_AT)
            begin
                drain();
                drained = 1'b1;
            end
            if ($urandom_range(0, 99) < 80)
            begin
                if ($urandom_range(0, 9) == 0)
                    period = $urandom_range(1, 60);
                else
                    period = $urandom_range(250, 1500);
                taps = $urandom_range(3, 10);
                for (int k = 0; k < taps; k++)
                begin
                    jitter   = int'($urandom_range(0, period / 5)) - period / 10;
                    interval = period + jitter;
                    queries  = $urandom_range(0, 4);
                    base     = now;
                    for (int j = 0; j < queries; j++)
                        send(REQ_QUERY, base + 32'((interval * (j + 1)) / (queries + 1)));
                    send(REQ_TAP, base + 32'(interval));
                end
            end
            else
            begin
                case ($urandom_range(0, 3))
                    0: send(1'($urandom_range(0, 1)), $urandom);
                    1: send(1'($urandom_range(0, 1)), now - 32'($urandom_range(1, 2000)));
                    2:
                    begin
                        send(REQ_TAP, now);
                        send(REQ_TAP, now);
                    end
                    default: send(1'($urandom_range(0, 1)), now + ($urandom >> $urandom_range(0, 31)));
                endcase
            end
        end

        // Wind down and give the verdict
        @(negedge clk);
        req_valid <= 1'b0;
        while (outstanding != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);
        if (mismatches == 0 && outstanding == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

### filelist.f
+incdir+sv
sv/ttb_pkg.sv
sv/tap_tempo_beat_tracker.sv
sim/beat_phase_checker.sv
sim/tb_top.sv
